### rtl/tga_pkg.sv
// Shared types and constants of the TGA run-length pixel decoder.
package tga_pkg;

	localparam int MAX_BYTES_PER_PIXEL = 4;
	localparam int WORD_W = 8 * MAX_BYTES_PER_PIXEL;
	localparam int BPOS_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
	localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

	localparam int OUTQ_DEPTH = 2;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	localparam logic [7:0] RUN_FLAG = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7f;

	typedef enum logic [1:0] {
		CFG_BPP    = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              is_run;
		logic [7:0]        count;
	} pix_evt_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0]  run_length;
		logic [15:0] column_start;
		logic [15:0] row_index;
		logic        line_end;
		logic        image_end;
		logic        packet_error;
	} result_t;

endpackage

### rtl/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA run-length pixel decoder.
// Input: one byte of compressed pixel data per transfer (push while full is low).
// Output: one result per finished pixel or run; the oldest result is on the ports while
// empty is low and leaves on pop. Header bytes and partial pixel bytes give none.
// Config: cfg_index 0 = bytes per pixel, 1 = image width, 2 = image height;
// cfg_ready is always high. Write only while the decoder is idle.
// Throughput: one byte per cycle while full is low; the front end parses and assembles
// in the cycle a byte is taken, the back end retires one pixel per cycle while the
// result queue has room. A pixel passes the event queue, then the result queue.
// A 4-entry event queue decouples front and back; a 2-entry result queue holds
// finished results, so a stalled receiver backs up into full without loss.
// After a packet crosses a line end or the image is complete, later bytes are
// still taken but discarded until reset.
// Reset: registers return to 4 bytes per pixel, width 1, height 1; all queues
// empty; the decoder waits for a packet header.
module tga_rle_pixel_decoder_unit import tga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  stream_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] pixel_value,
	output logic [7:0]  run_length,
	output logic [15:0] column_start,
	output logic [15:0] row_index,
	output logic        line_end,
	output logic        image_end,
	output logic        packet_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [2:0]  bpp_q;
	logic [15:0] width_q;
	logic [15:0] height_q;

	logic     ev_push;
	pix_evt_t ev_wr;
	logic     ev_full;
	logic     ev_pop;
	logic     ev_empty;
	pix_evt_t ev_rd;
	result_t  res;

	assign cfg_ready = 1'b1;
	assign full      = ev_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= 3'd4;
			width_q  <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BPP:    bpp_q    <= cfg_data[2:0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	tga_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.evq_full        (ev_full),
		.stream_byte     (stream_byte),
		.bytes_per_pixel (bpp_q),
		.ev_push         (ev_push),
		.ev_data         (ev_wr)
	);

	tga_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev_wr),
		.full    (ev_full),
		.rd_en   (ev_pop),
		.empty   (ev_empty),
		.rd_data (ev_rd)
	);

	tga_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_empty     (ev_empty),
		.ev_data      (ev_rd),
		.ev_pop       (ev_pop),
		.image_width  (width_q),
		.image_height (height_q),
		.pop          (pop),
		.empty        (empty),
		.res          (res)
	);

	assign pixel_value  = res.pixel_value;
	assign run_length   = res.run_length;
	assign column_start = res.column_start;
	assign row_index    = res.row_index;
	assign line_end     = res.line_end;
	assign image_end    = res.image_end;
	assign packet_error = res.packet_error;

endmodule

### rtl/tga_front.sv
// Front end: packet header parsing and little-endian pixel byte assembly.
module tga_front import tga_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             evq_full,
	input  logic [7:0]       stream_byte,
	input  logic [2:0]       bytes_per_pixel,
	output logic             ev_push,
	output pix_evt_t         ev_data
);

	logic              hdr_q;
	logic              is_run_q;
	logic [7:0]        left_q;
	logic [BPOS_W-1:0] bpos_q;
	logic [WORD_W-1:0] word_q;

	logic              take;
	logic [2:0]        bpp_eff;
	logic              last_byte;
	logic [WORD_W-1:0] word_new;
	logic [7:0]        left_dec;

	always_comb begin
		if (bytes_per_pixel == 3'd0) begin
			bpp_eff = 3'd1;
		end else if (bytes_per_pixel > 3'(MAX_BYTES_PER_PIXEL)) begin
			bpp_eff = 3'(MAX_BYTES_PER_PIXEL);
		end else begin
			bpp_eff = bytes_per_pixel;
		end
	end

	assign take      = push && !evq_full;
	assign last_byte = (3'(bpos_q) + 3'd1) >= bpp_eff;
	assign word_new  = word_q | (WORD_W'(stream_byte) << {bpos_q, 3'b000});
	assign left_dec  = left_q - 8'd1;

	assign ev_push        = take && !hdr_q && last_byte;
	assign ev_data.word   = word_new;
	assign ev_data.is_run = is_run_q;
	assign ev_data.count  = left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= 1'b1;
			is_run_q <= 1'b0;
			left_q   <= '0;
			bpos_q   <= '0;
			word_q   <= '0;
		end else if (take) begin
			if (hdr_q) begin
				is_run_q <= (stream_byte & RUN_FLAG) != 8'd0;
				left_q   <= (stream_byte & COUNT_MASK) + 8'd1;
				hdr_q    <= 1'b0;
				bpos_q   <= '0;
				word_q   <= '0;
			end else if (!last_byte) begin
				word_q <= word_new;
				bpos_q <= bpos_q + 1'b1;
			end else begin
				word_q <= '0;
				bpos_q <= '0;
				if (is_run_q) begin
					left_q <= '0;
					hdr_q  <= 1'b1;
				end else begin
					left_q <= left_dec;
					hdr_q  <= (left_dec == 8'd0);
				end
			end
		end
	end

endmodule

### rtl/tga_evq.sv
// Pixel event queue between the front end and the back end.
module tga_evq import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  pix_evt_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output logic     empty,
	output pix_evt_t rd_data
);

	pix_evt_t               mem_q [EVQ_DEPTH];
	logic [EVQ_PTR_W-1:0]   wr_ptr_q;
	logic [EVQ_PTR_W-1:0]   rd_ptr_q;
	logic [EVQ_CNT_W-1:0]   cnt_q;

	assign full    = cnt_q == EVQ_CNT_W'(EVQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + EVQ_CNT_W'(wr_en) - EVQ_CNT_W'(rd_en);
		end
	end

endmodule

### rtl/tga_back.sv
// Back end: column and line tracking, run clipping, and the result queue.
module tga_back import tga_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_empty,
	input  pix_evt_t    ev_data,
	output logic        ev_pop,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	input  logic        pop,
	output logic        empty,
	output result_t     res
);

	logic [15:0]           col_q;
	logic [15:0]           line_q;
	logic                  halted_q;
	result_t               oq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] oq_wr_q;
	logic [OUTQ_PTR_W-1:0] oq_rd_q;
	logic [OUTQ_CNT_W-1:0] oq_cnt_q;

	logic        oq_full;
	logic        oq_push;
	logic        oq_pop;
	logic [15:0] w;
	logic [15:0] h;
	logic [15:0] remaining;
	logic [7:0]  run;
	logic        err;
	logic        lend;
	logic        iend;
	result_t     res_new;

	assign oq_full = oq_cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH);
	assign empty   = oq_cnt_q == '0;
	assign res     = oq_q[oq_rd_q];
	assign oq_pop  = pop && !empty;
	assign ev_pop  = !ev_empty && (halted_q || !oq_full);
	assign oq_push = ev_pop && !halted_q;

	always_comb begin
		w         = (image_width == 16'd0) ? 16'd1 : image_width;
		h         = (image_height == 16'd0) ? 16'd1 : image_height;
		remaining = (col_q < w) ? (w - col_q) : 16'd1;
		if (ev_data.is_run) begin
			if (16'(ev_data.count) > remaining) begin
				run = remaining[7:0];
				err = 1'b1;
			end else begin
				run = ev_data.count;
				err = 1'b0;
			end
		end else begin
			run = 8'd1;
			err = (remaining == 16'd1) && (ev_data.count != 8'd1);
		end
		lend = 16'(run) == remaining;
		iend = lend && (({1'b0, line_q} + 17'd1) >= {1'b0, h});
		res_new.pixel_value  = 32'(ev_data.word);
		res_new.run_length   = run;
		res_new.column_start = col_q;
		res_new.row_index    = h - line_q - 16'd1;
		res_new.line_end     = lend;
		res_new.image_end    = iend;
		res_new.packet_error = err;
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			line_q   <= '0;
			halted_q <= 1'b0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				if (lend) begin
					col_q  <= '0;
					line_q <= line_q + 16'd1;
				end else begin
					col_q <= col_q + 16'(run);
				end
				if (err || iend) begin
					halted_q <= 1'b1;
				end
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + OUTQ_CNT_W'(oq_push) - OUTQ_CNT_W'(oq_pop);
		end
	end

endmodule

### rtl/tga_checker.sv
// Port-level checks of the TGA run-length pixel decoder, bound to the top level.
module tga_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  run_length,
	input logic        line_end,
	input logic        image_end,
	input logic        packet_error
);

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> run_length != 8'd0)
		else $error("result with zero run length");

	a_end_implies_line: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (image_end || packet_error) |-> line_end)
		else $error("image end or packet error without line end");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && (image_end || packet_error) |=> empty)
		else $error("result after image end or packet error");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result dropped");

endmodule

bind tga_rle_pixel_decoder_unit tga_checker u_tga_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.run_length   (run_length),
	.line_end     (line_end),
	.image_end    (image_end),
	.packet_error (packet_error)
);
